// File: hdl/midi_channel_message_parser_macros.svh
// ----------------------------------------------------------------------------
// MIDI channel message parser assertion macros
// Concurrent assertion wrappers; empty bodies when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MIDI_CHANNEL_MESSAGE_PARSER_MACROS_SVH
`define MIDI_CHANNEL_MESSAGE_PARSER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define MCP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication
`define MCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MCP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define MCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/mcp_pkg.sv
// ----------------------------------------------------------------------------
// MIDI channel message parser package
// Shared types and codes for the parser decode and output stages.
// ----------------------------------------------------------------------------
package mcp_pkg;

	localparam logic [2:0] KIND_NOTE_OFF = 3'd0;
	localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
	localparam logic [2:0] KIND_CONTROL  = 3'd2;
	localparam logic [2:0] KIND_BEND     = 3'd3;
	localparam logic [2:0] KIND_OTHER    = 3'd4;

	localparam logic [7:0] BYTE_REALTIME = 8'hF8;
	localparam logic [7:0] BYTE_SYSTEM   = 8'hF0;

	localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
	localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
	localparam logic [3:0] TYPE_CONTROL  = 4'hB;
	localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
	localparam logic [3:0] TYPE_PRESSURE = 4'hD;
	localparam logic [3:0] TYPE_BEND     = 4'hE;

	typedef struct packed {
		logic [7:0] running_status;
		logic [1:0] data_count;
		logic [1:0] expected_count;
		logic [6:0] first_data;
		logic       msb_pending;
		logic [3:0] msb_channel;
		logic [4:0] msb_controller;
		logic [6:0] msb_value;
	} state_t;

	typedef struct packed {
		logic        wide_value;
		logic [13:0] event_value;
		logic [6:0]  event_number;
		logic [3:0]  event_channel;
		logic [2:0]  event_kind;
	} event_t;

endpackage

// File: hdl/midi_channel_message_parser.sv
// ----------------------------------------------------------------------------
// MIDI channel message parser
// Running-status decoder for MIDI channel voice messages.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one raw MIDI byte per word in tdata[7:0].
//   m_axis carries one decoded event per completed message; status bytes,
//   realtime bytes, first data bytes and orphan data give no word.
//   A byte is held in the input register, is decoded against the
//   running-status registers and lands in the output register, so an event
//   word is offered once its last byte has passed both registers.
//   Throughput is one byte per cycle while the receiver does not stall;
//   the decode between the two registers is combinational and the only path.
//   When the receiver stalls, the event waits in the output register and
//   the input register holds the next byte; non-event bytes keep flowing
//   until a second event would need the output register.
//   Reset clears running status, counts and the pending controller MSB,
//   and empties both registers.
// ----------------------------------------------------------------------------
`include "midi_channel_message_parser_macros.svh"

module midi_channel_message_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [3:0] event_channel, [10:4] event_number,
	                                    // [24:11] event_value, [31:25] zero
	output logic [3:0]  m_axis_tuser    // [2:0] event_kind, [3] wide_value
);

	logic            valid_s1;
	logic [7:0]      data_s1;
	mcp_pkg::state_t state_q;
	mcp_pkg::state_t state_nxt;
	logic            ev_valid;
	mcp_pkg::event_t ev;
	mcp_pkg::event_t ev_out;
	logic            out_free;
	logic            s1_go;
	logic            s_accept;

	assign s1_go         = valid_s1 && (!ev_valid || out_free);
	assign s_axis_tready = !valid_s1 || s1_go;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			data_s1 <= s_axis_tdata;
		end
	end

	// advance parser state only when the byte leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (s1_go) begin
			state_q <= state_nxt;
		end
	end

	mcp_decode u_decode (
		.state     (state_q),
		.data_byte (data_s1),
		.state_nxt (state_nxt),
		.ev_valid  (ev_valid),
		.ev        (ev)
	);

	mcp_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (s1_go && ev_valid),
		.ev     (ev),
		.free   (out_free),
		.valid  (m_axis_tvalid),
		.ready  (m_axis_tready),
		.ev_out (ev_out)
	);

	assign m_axis_tdata = {7'd0, ev_out.event_value, ev_out.event_number,
		ev_out.event_channel};
	assign m_axis_tuser = {ev_out.wide_value, ev_out.event_kind};

	`MCP_ASSERT_NEXT(a_event_lands, clk, arst_n, s1_go && ev_valid, m_axis_tvalid)
	`MCP_ASSERT_IMPLY(a_hires_kind, clk, arst_n, m_axis_tvalid && m_axis_tuser[3],
		m_axis_tuser[2:0] == mcp_pkg::KIND_CONTROL || m_axis_tuser[2:0] == mcp_pkg::KIND_BEND)
	`MCP_ASSERT_IMPLY(a_lores_value, clk, arst_n, m_axis_tvalid && !m_axis_tuser[3],
		m_axis_tdata[24:18] == 7'd0)
	`MCP_ASSERT_IMPLY(a_no_status_idle, clk, arst_n, state_q.running_status == 8'd0,
		state_q.data_count == 2'd0 && state_q.expected_count == 2'd0)

endmodule

// File: hdl/mcp_decode.sv
// ----------------------------------------------------------------------------
// MIDI channel message parser decode
// Next-state and event logic for one MIDI byte under running status.
// ----------------------------------------------------------------------------
module mcp_decode (
	input  mcp_pkg::state_t state,
	input  logic [7:0]      data_byte,
	output mcp_pkg::state_t state_nxt,
	output logic            ev_valid,
	output mcp_pkg::event_t ev
);

	always_comb begin
		logic [6:0] d0;
		logic [6:0] d1;
		logic [3:0] chan;
		state_nxt = state;
		ev_valid  = 1'b0;
		ev        = '0;
		d0        = data_byte[6:0];
		d1        = 7'd0;
		chan      = state.running_status[3:0];
		if (data_byte >= mcp_pkg::BYTE_REALTIME) begin
			// realtime: ignore
		end else if (data_byte[7]) begin
			if (data_byte >= mcp_pkg::BYTE_SYSTEM) begin
				state_nxt.running_status = 8'd0;
				state_nxt.expected_count = 2'd0;
				state_nxt.data_count     = 2'd0;
				state_nxt.msb_pending    = 1'b0;
			end else begin
				state_nxt.running_status = data_byte;
				state_nxt.data_count     = 2'd0;
				if (data_byte[7:4] == mcp_pkg::TYPE_PROGRAM
						|| data_byte[7:4] == mcp_pkg::TYPE_PRESSURE) begin
					state_nxt.expected_count = 2'd1;
				end else begin
					state_nxt.expected_count = 2'd2;
				end
			end
		end else if (state.running_status == 8'd0) begin
			// orphan data: drop
		end else if (state.expected_count[1] && state.data_count == 2'd0) begin
			state_nxt.first_data = data_byte[6:0];
			state_nxt.data_count = 2'd1;
		end else begin
			if (state.expected_count[1]) begin
				d0 = state.first_data;
				d1 = data_byte[6:0];
			end
			state_nxt.data_count = 2'd0;
			ev_valid             = 1'b1;
			ev.event_channel     = chan;
			ev.event_number      = d0;
			ev.event_value       = {7'd0, d1};
			state_nxt.msb_pending = 1'b0;
			unique case (state.running_status[7:4])
				mcp_pkg::TYPE_NOTE_OFF: ev.event_kind = mcp_pkg::KIND_NOTE_OFF;
				mcp_pkg::TYPE_NOTE_ON: begin
					ev.event_kind = (d1 == 7'd0) ? mcp_pkg::KIND_NOTE_OFF
						: mcp_pkg::KIND_NOTE_ON;
				end
				mcp_pkg::TYPE_BEND: begin
					ev.event_kind   = mcp_pkg::KIND_BEND;
					ev.event_number = 7'd0;
					ev.event_value  = {d1, d0};
					ev.wide_value   = 1'b1;
				end
				mcp_pkg::TYPE_CONTROL: begin
					ev.event_kind = mcp_pkg::KIND_CONTROL;
					if (d0[6:5] == 2'b01 && state.msb_pending
							&& state.msb_channel == chan
							&& state.msb_controller == d0[4:0]) begin
						// merge LSB with the held MSB
						ev.event_number = {2'b00, state.msb_controller};
						ev.event_value  = {state.msb_value, d1};
						ev.wide_value   = 1'b1;
					end else if (d0[6:5] == 2'b00) begin
						state_nxt.msb_pending    = 1'b1;
						state_nxt.msb_channel    = chan;
						state_nxt.msb_controller = d0[4:0];
						state_nxt.msb_value      = d1;
					end
				end
				default: ev.event_kind = mcp_pkg::KIND_OTHER;
			endcase
		end
	end

endmodule

// File: hdl/mcp_out_reg.sv
// ----------------------------------------------------------------------------
// MIDI channel message parser output register
// Holds one event until the downstream side takes it.
// ----------------------------------------------------------------------------
module mcp_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  mcp_pkg::event_t ev,
	output logic            free,
	output logic            valid,
	input  logic            ready,
	output mcp_pkg::event_t ev_out
);

	logic            valid_s2;
	mcp_pkg::event_t event_s2;

	assign free   = !valid_s2 || ready;
	assign valid  = valid_s2;
	assign ev_out = event_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			event_s2 <= ev;
		end
	end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// MIDI channel message parser testbench
// Streams directed and random MIDI byte traffic into the parser, decodes the
// same bytes in a running-status model of its own and checks every event
// word field by field. Both stream sides idle at random, and one long
// receiver stall backs the parser up into its input.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [3:0] TYPE_POLY = 4'hA;
	localparam int LONG_HOLD = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 8;

	typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_FULL} idle_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;

	logic [7:0]      midi_byte_q[$];
	mcp_pkg::event_t midi_event_q[$];
	mcp_pkg::state_t parse_st = '0;
	mcp_pkg::event_t want_ev;

	idle_mode_t src_mode = IDLE_NONE;
	idle_mode_t snk_mode = IDLE_NONE;
	int         src_wait = 0;
	int         snk_wait = 0;
	int         snk_draw;
	int         hold_left = 0;
	int         stall_req = 0;
	int         stall_seen = 0;
	logic       byte_taken = 1'b0;
	logic       word_taken = 1'b0;
	int         mismatch_count = 0;
	int         queued = 0;
	logic [7:0] gen_status = '0;

	const logic [3:0] msg_types[7] = '{mcp_pkg::TYPE_NOTE_OFF, mcp_pkg::TYPE_NOTE_ON,
		TYPE_POLY, mcp_pkg::TYPE_CONTROL, mcp_pkg::TYPE_PROGRAM, mcp_pkg::TYPE_PRESSURE,
		mcp_pkg::TYPE_BEND};

	midi_channel_message_parser DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int draw_idle(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: return 0;
			IDLE_FULL: return $urandom_range(0, 18);
			default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
		endcase
	endfunction

	// Running-status decode of one byte; completed messages go onto midi_event_q.
	task automatic decode_midi_byte(input logic [7:0] b);
		logic [3:0]      msg_type;
		logic [3:0]      chan;
		logic [6:0]      d0;
		logic [6:0]      d1;
		mcp_pkg::event_t ev;
		if (b >= mcp_pkg::BYTE_REALTIME)
			return;
		if (b[7]) begin
			if (b >= mcp_pkg::BYTE_SYSTEM) begin
				parse_st.running_status = '0;
				parse_st.expected_count = '0;
				parse_st.data_count = '0;
				parse_st.msb_pending = 1'b0;
			end else begin
				parse_st.running_status = b;
				parse_st.expected_count = (b[7:4] == mcp_pkg::TYPE_PROGRAM
					|| b[7:4] == mcp_pkg::TYPE_PRESSURE) ? 2'd1 : 2'd2;
				parse_st.data_count = '0;
			end
			return;
		end
		if (parse_st.running_status == '0)
			return;
		if (parse_st.expected_count >= 2 && parse_st.data_count == 0) begin
			parse_st.first_data = b[6:0];
			parse_st.data_count = 2'd1;
			return;
		end
		if (parse_st.expected_count >= 2) begin
			d0 = parse_st.first_data;
			d1 = b[6:0];
		end else begin
			d0 = b[6:0];
			d1 = '0;
		end
		parse_st.data_count = '0;
		msg_type = parse_st.running_status[7:4];
		chan = parse_st.running_status[3:0];

		ev = '0;
		ev.event_channel = chan;
		ev.event_number = d0;
		ev.event_value = {7'd0, d1};
		case (msg_type)
			mcp_pkg::TYPE_NOTE_OFF: begin
				parse_st.msb_pending = 1'b0;
				ev.event_kind = mcp_pkg::KIND_NOTE_OFF;
			end
			mcp_pkg::TYPE_NOTE_ON: begin
				parse_st.msb_pending = 1'b0;
				ev.event_kind = (d1 == 0) ? mcp_pkg::KIND_NOTE_OFF : mcp_pkg::KIND_NOTE_ON;
			end
			mcp_pkg::TYPE_BEND: begin
				parse_st.msb_pending = 1'b0;
				ev.event_kind = mcp_pkg::KIND_BEND;
				ev.event_number = '0;
				ev.event_value = {d1, d0};
				ev.wide_value = 1'b1;
			end
			mcp_pkg::TYPE_CONTROL: begin
				ev.event_kind = mcp_pkg::KIND_CONTROL;
				// LSB 32..63 right after its MSB on the same channel merges into 14 bits
				if (d0 >= 32 && d0 < 64 && parse_st.msb_pending
						&& parse_st.msb_channel == chan
						&& parse_st.msb_controller == d0[4:0]) begin
					parse_st.msb_pending = 1'b0;
					ev.event_number = {2'b00, parse_st.msb_controller};
					ev.event_value = {parse_st.msb_value, d1};
					ev.wide_value = 1'b1;
				end else if (d0 < 32) begin
					parse_st.msb_pending = 1'b1;
					parse_st.msb_channel = chan;
					parse_st.msb_controller = d0[4:0];
					parse_st.msb_value = d1;
				end else begin
					parse_st.msb_pending = 1'b0;
				end
			end
			default: begin
				parse_st.msb_pending = 1'b0;
				ev.event_kind = mcp_pkg::KIND_OTHER;
			end
		endcase
		midi_event_q.insert(midi_event_q.size(), ev);
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// Check event words first, then decode the byte taken at the same edge.
	always @(posedge clk) begin
		byte_taken <= arst_n && s_axis_tvalid && s_axis_tready;
		word_taken <= arst_n && m_axis_tvalid && m_axis_tready;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (midi_event_q.size() == 0) begin
				$error("event word with none expected: tdata %h, tuser %h",
					m_axis_tdata, m_axis_tuser);
				mismatch_count++;
			end else begin
				want_ev = midi_event_q.pop_front();
				check_field("event_kind", 16'(want_ev.event_kind), 16'(m_axis_tuser[2:0]));
				check_field("event_channel", 16'(want_ev.event_channel), 16'(m_axis_tdata[3:0]));
				check_field("event_number", 16'(want_ev.event_number), 16'(m_axis_tdata[10:4]));
				check_field("event_value", 16'(want_ev.event_value), 16'(m_axis_tdata[24:11]));
				check_field("wide_value", 16'(want_ev.wide_value), 16'(m_axis_tuser[3]));
				check_field("tdata pad", 16'd0, 16'(m_axis_tdata[31:25]));
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready)
			decode_midi_byte(s_axis_tdata);
	end

	// Byte source: hold the word until taken, then wait the drawn gap.
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || byte_taken)) begin
			if (src_wait > 0) begin
				src_wait <= src_wait - 1;
				s_axis_tvalid <= 1'b0;
			end else if (midi_byte_q.size() > 0) begin
				s_axis_tdata <= midi_byte_q.pop_front();
				s_axis_tvalid <= 1'b1;
				src_wait <= draw_idle(src_mode);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Event sink: long hold on request, otherwise a drawn stall after each word.
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_req != stall_seen) begin
				stall_seen <= stall_req;
				hold_left <= LONG_HOLD;
				m_axis_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else if (snk_wait > 0) begin
				snk_wait <= snk_wait - 1;
				m_axis_tready <= 1'b0;
			end else if (word_taken) begin
				snk_draw = draw_idle(snk_mode);
				snk_wait <= (snk_draw > 0) ? snk_draw - 1 : 0;
				m_axis_tready <= (snk_draw == 0);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_top: FAIL");
		$finish;
	end

	task automatic push_byte(input logic [7:0] b);
		midi_byte_q.insert(midi_byte_q.size(), b);
		queued++;
	endtask

	// Data byte, now and then with a realtime byte slipped in front.
	task automatic push_data(input logic [6:0] d);
		if ($urandom_range(0, 19) == 0)
			push_byte(mcp_pkg::BYTE_REALTIME + 8'($urandom_range(0, 7)));
		push_byte({1'b0, d});
	endtask

	// Status byte, often left out when running status already covers it.
	task automatic push_status(input logic [3:0] msg_type, input logic [3:0] chan);
		if (gen_status != {msg_type, chan} || $urandom_range(0, 2) == 0)
			push_byte({msg_type, chan});
		gen_status = {msg_type, chan};
	endtask

	function automatic logic [6:0] data7();
		case ($urandom_range(0, 7))
			0:       return 7'd0;
			1:       return 7'd127;
			default: return 7'($urandom_range(0, 127));
		endcase
	endfunction

	// Controller MSB followed by its LSB, sometimes broken on purpose.
	task automatic queue_controller_pair();
		logic [3:0] chan;
		logic [4:0] ctl;
		logic [6:0] lsb_ctl;
		chan = 4'($urandom_range(0, 15));
		ctl = 5'($urandom_range(0, 31));
		lsb_ctl = {2'b01, ctl};
		push_status(mcp_pkg::TYPE_CONTROL, chan);
		push_data({2'b00, ctl});
		push_data(data7());
		case ($urandom_range(0, 9))
			0: begin
				push_byte({mcp_pkg::TYPE_CONTROL, chan});
			end
			1: push_status(mcp_pkg::TYPE_CONTROL, chan + 4'd1);
			2: lsb_ctl[4:0] = ctl + 5'($urandom_range(1, 31));
			3: begin
				push_byte(mcp_pkg::BYTE_SYSTEM + 8'($urandom_range(0, 7)));
				gen_status = '0;
				push_status(mcp_pkg::TYPE_CONTROL, chan);
			end
			4: begin
				push_status(mcp_pkg::TYPE_NOTE_ON, chan);
				push_data(data7());
				push_data(data7());
				push_status(mcp_pkg::TYPE_CONTROL, chan);
			end
			default: ;
		endcase
		push_data(lsb_ctl);
		push_data(data7());
	endtask

	task automatic queue_random_traffic(input int n);
		int         target;
		int         pick;
		logic [3:0] msg_type;
		target = queued + n;
		while (queued < target) begin
			pick = $urandom_range(0, 99);
			msg_type = msg_types[$urandom_range(0, 6)];
			if (pick < 18) begin
				queue_controller_pair();
			end else if (pick < 25) begin
				push_byte(8'($urandom_range(0, 255)));
			end else if (pick < 28) begin
				push_byte(mcp_pkg::BYTE_SYSTEM + 8'($urandom_range(0, 7)));
				gen_status = '0;
			end else if (pick < 32) begin
				// status and a single data byte (cut short for two-data-byte types)
				push_status(msg_type, 4'($urandom_range(0, 15)));
				push_data(data7());
			end else begin
				push_status(msg_type, 4'($urandom_range(0, 15)));
				push_data(data7());
				if (msg_type != mcp_pkg::TYPE_PROGRAM && msg_type != mcp_pkg::TYPE_PRESSURE)
					push_data(data7());
			end
		end
	endtask

	task automatic drain();
		while (midi_byte_q.size() != 0 || s_axis_tvalid || midi_event_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(input int n, input idle_mode_t src_m, input idle_mode_t snk_m);
		src_mode = src_m;
		snk_mode = snk_m;
		queue_random_traffic(n);
		drain();
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed traffic
		src_mode = IDLE_SOME;
		snk_mode = IDLE_SOME;
		push_byte(8'h45);
		push_byte({mcp_pkg::TYPE_NOTE_ON, 4'h0});
		push_byte(8'h3C);
		push_byte(8'h7F);
		push_byte(8'h3C);
		push_byte(8'h00);
		push_byte({mcp_pkg::TYPE_NOTE_OFF, 4'hF});
		push_byte(8'h7F);
		push_byte(mcp_pkg::BYTE_REALTIME + 8'd7);
		push_byte(8'h40);
		push_byte({mcp_pkg::TYPE_CONTROL, 4'h3});
		push_byte(8'h07);
		push_byte(8'h64);
		push_byte(8'h27);
		push_byte(8'h10);
		push_byte(8'h1F);
		push_byte(8'h7F);
		push_byte(mcp_pkg::BYTE_SYSTEM + 8'd7);
		push_byte({mcp_pkg::TYPE_CONTROL, 4'h3});
		push_byte(8'h3F);
		push_byte(8'h00);
		push_byte({mcp_pkg::TYPE_PROGRAM, 4'h5});
		push_byte(8'h7F);
		push_byte({mcp_pkg::TYPE_BEND, 4'hF});
		push_byte(8'h7F);
		push_byte(8'h7F);
		push_byte({TYPE_POLY, 4'h1});
		push_byte(8'h12);
		push_byte(8'h34);
		drain();

		run_phase(300, IDLE_NONE, IDLE_NONE);
		run_phase(300, IDLE_FULL, IDLE_FULL);
		// hold the sink off while bytes keep coming
		stall_req++;
		run_phase(250, IDLE_NONE, IDLE_NONE);
		run_phase(400, IDLE_SOME, IDLE_SOME);

		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && midi_event_q.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
